// ===== hdl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies; imported by the controller, datapath and top level.
package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_BACK  = 3'd1,
		REQ_INS_POS   = 3'd2,
		REQ_DEL_FRONT = 3'd3,
		REQ_DEL_BACK  = 3'd4,
		REQ_SEARCH    = 3'd5,
		REQ_LENGTH    = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BAD_POS   = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_sts_t;

	// counts wider than 8 bits saturate at 255
	function automatic logic [7:0] sat8(input logic [LEN_W-1:0] v);
		if (32'(v) > 32'd255) begin
			return 8'hFF;
		end
		return 8'(v);
	endfunction

endpackage

// ===== hdl/ole_ctrl.sv =====
// Request sequencer for the ordered list engine: capture, execute, done strobe.
// Depends on ole_pkg.
module ole_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ole_pkg::dp_sts_t sts,
	output logic            busy,
	output logic            done,
	output ole_pkg::dp_cmd_t cmd
);
	import ole_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_n;
	logic   done_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= cmd.exec;
		end
	end

	assign busy     = (state_q == S_EXEC);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
	assign done     = done_q;

	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("load not followed by exec");
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (done && !cmd.exec)) else $error("exec not followed by done");
	a_never_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty)) else $error("list both full and empty");

endmodule

// ===== hdl/ole_dp.sv =====
// Shift-cell list datapath: request capture, cells, length, result registers.
// Depends on ole_pkg.
module ole_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  ole_pkg::dp_cmd_t cmd,
	input  logic [2:0]       req_type,
	input  logic [31:0]      item_value,
	input  logic [7:0]       insert_position,
	output ole_pkg::dp_sts_t sts,
	output logic [2:0]       status,
	output logic [31:0]      removed_value,
	output logic [7:0]       found_position,
	output logic [7:0]       list_length
);
	import ole_pkg::*;

	req_t             req_q;
	logic [31:0]      val_q;
	logic [7:0]       pos_q;
	logic [31:0]      cells_q [CAPACITY];
	logic [LEN_W-1:0] len_q, len_n;
	status_t          status_q, status_n;
	logic [31:0]      removed_q, removed_n;
	logic [LEN_W-1:0] found_q, found_n;

	logic             full, empty, pos_ok, hit;
	logic             do_ins, do_del_front, do_del_back;
	logic [LEN_W-1:0] ins_idx, hit_pos, last_idx;

	assign full     = (len_q == LEN_W'(CAPACITY));
	assign empty    = (len_q == '0);
	assign pos_ok   = (pos_q != 8'd0) && (10'(pos_q) <= (10'(len_q) + 10'd1));
	assign last_idx = len_q - LEN_W'(1);

	// first match wins
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if ((LEN_W'(i) < len_q) && (cells_q[i] == val_q)) begin
				hit     = 1'b1;
				hit_pos = LEN_W'(i + 1);
			end
		end
	end

	always_comb begin
		do_ins       = 1'b0;
		do_del_front = 1'b0;
		do_del_back  = 1'b0;
		ins_idx      = '0;
		status_n     = ST_OK;
		removed_n    = '0;
		found_n      = '0;
		len_n        = len_q;
		case (req_q) inside
			REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
				if (full) begin
					status_n = ST_FULL;
				end else if (req_q == REQ_INS_FRONT) begin
					do_ins = 1'b1;
				end else if (req_q == REQ_INS_BACK) begin
					do_ins  = 1'b1;
					ins_idx = len_q;
				end else if (!pos_ok) begin
					status_n = ST_BAD_POS;
				end else begin
					do_ins  = 1'b1;
					ins_idx = LEN_W'(pos_q) - LEN_W'(1);
				end
				if (do_ins) begin
					len_n = len_q + LEN_W'(1);
				end
			end
			REQ_DEL_FRONT, REQ_DEL_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					len_n = last_idx;
					if (req_q == REQ_DEL_FRONT) begin
						do_del_front = 1'b1;
						removed_n    = cells_q[0];
					end else begin
						do_del_back = 1'b1;
						removed_n   = cells_q[last_idx[IDX_W-1:0]];
					end
				end
			end
			REQ_SEARCH: begin
				if (hit) begin
					found_n = hit_pos;
				end else begin
					status_n = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(req_type);
			val_q <= item_value;
			pos_q <= insert_position;
		end
		if (cmd.exec) begin
			status_q  <= status_n;
			removed_q <= removed_n;
			found_q   <= found_n;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_ins) begin
					if (LEN_W'(g) == ins_idx) begin
						cells_q[g] <= val_q;
					end else if (LEN_W'(g) > ins_idx) begin
						if (g > 0) begin
							cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
						end
					end
				end else if (do_del_front) begin
					if (g < CAPACITY - 1) begin
						cells_q[g] <= cells_q[(g < CAPACITY - 1) ? g + 1 : g];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.exec) begin
			len_q <= len_n;
		end
	end

	assign sts.full       = full;
	assign sts.empty      = empty;
	assign status         = status_q;
	assign removed_value  = removed_q;
	assign found_position = sat8(found_q);
	assign list_length    = sat8(len_q);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY)) else $error("length above capacity");
	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(len_q)) else $error("length moved without exec");
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_ins) |=> (len_q == $past(len_q) + LEN_W'(1)))
		else $error("insert did not grow list");
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (do_del_front || do_del_back)) |=> (len_q == $past(len_q) - LEN_W'(1)))
		else $error("delete did not shrink list");

endmodule

// ===== hdl/ordered_list_engine_core.sv =====
// Ordered list engine, top level: a shift-cell list of signed 32-bit values.
// A request is captured at the accepting edge, then executed in the cells in the EXEC state;
// done rises as the results are registered. No new request is taken while busy (EXEC).
// Reset clears the length and the sequencer; cell contents are left undefined.
// The done strobe lasts one cycle and is not held off by the receiver.
// Depends on ole_pkg, ole_ctrl, ole_dp.
module ordered_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] item_value,
	input  logic [7:0]  insert_position,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] removed_value,
	output logic [7:0]  found_position,
	output logic [7:0]  list_length
);
	import ole_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ole_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ole_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_type        (req_type),
		.item_value      (item_value),
		.insert_position (insert_position),
		.sts             (sts),
		.status          (status),
		.removed_value   (removed_value),
		.found_position  (found_position),
		.list_length     (list_length)
	);

endmodule

// ===== tb/ordered_list_engine_checker.sv =====
// Checker for the ordered list engine: predicts each accepted request's result
// and compares it against the done strobe. Depends on ole_pkg.
module ordered_list_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] item_value,
	input  logic [7:0]  insert_position,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [31:0] removed_value,
	input  logic [7:0]  found_position,
	input  logic [7:0]  list_length,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ole_pkg::*;

	typedef struct {
		status_t     st;
		logic [31:0] removed;
		logic [7:0]  found;
		logic [7:0]  len;
	} list_result_t;

	logic [31:0]  cells [CAPACITY];
	int unsigned  count;
	list_result_t expected_results [$];
	list_result_t oldest;
	int           mismatches = 0;
	int           results_seen = 0;

	assign fail_count = mismatches;

	function automatic logic [7:0] clip8(input int unsigned v);
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	function automatic list_result_t predict_request(input logic [2:0] op,
			input logic [31:0] value, input logic [7:0] pos);
		list_result_t r;
		int unsigned  at;
		r.st = ST_OK;
		r.removed = '0;
		r.found = '0;
		case (op) inside
			REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
				if (count >= CAPACITY) begin
					r.st = ST_FULL;
				end else if (op == REQ_INS_POS && (pos == 8'd0 || 32'(pos) > count + 1)) begin
					r.st = ST_BAD_POS;
				end else begin
					if (op == REQ_INS_FRONT) begin
						at = 0;
					end else if (op == REQ_INS_BACK) begin
						at = count;
					end else begin
						at = 32'(pos) - 1;
					end
					for (int unsigned i = count; i > at; i--) begin
						cells[i] = cells[i - 1];
					end
					cells[at] = value;
					count++;
				end
			end
			REQ_DEL_FRONT: begin
				if (count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.removed = cells[0];
					for (int unsigned i = 1; i < count; i++) begin
						cells[i - 1] = cells[i];
					end
					count--;
				end
			end
			REQ_DEL_BACK: begin
				if (count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.removed = cells[count - 1];
					count--;
				end
			end
			REQ_SEARCH: begin
				r.st = ST_NOT_FOUND;
				for (int unsigned i = 0; i < count; i++) begin
					if (r.st == ST_NOT_FOUND && cells[i] == value) begin
						r.st = ST_OK;
						r.found = clip8(i + 1);
					end
				end
			end
			default: begin
			end
		endcase
		r.len = clip8(count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= 40) begin
			$display("[%0t] result %0d: %s expected %0h got %0h", $realtime, results_seen,
				what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request pending", 0, 1);
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.st) begin
						report_mismatch("status", oldest.st, status);
					end
					if (removed_value !== oldest.removed) begin
						report_mismatch("removed_value", oldest.removed, removed_value);
					end
					if (found_position !== oldest.found) begin
						report_mismatch("found_position", oldest.found, found_position);
					end
					if (list_length !== oldest.len) begin
						report_mismatch("list_length", oldest.len, list_length);
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(predict_request(req_type, item_value, insert_position));
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/ordered_list_engine_core_tb.sv =====
// Testbench top for ordered_list_engine_core: directed and random requests with
// sender idling; verdict from ordered_list_engine_checker. Depends on ole_pkg.
module ordered_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ole_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int PER_PHASE = 178;
	localparam int BLOCK_LEN = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [31:0] item_value = '0;
	logic [7:0]  insert_position = '0;
	logic        done;
	logic [2:0]  status;
	logic [31:0] removed_value;
	logic [7:0]  found_position;
	logic [7:0]  list_length;
	int          fail_count;
	int          pending;

	logic [31:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_002A, 32'h5A5A_5A5A, 32'hA5A5_A5A5};

	ordered_list_engine_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.item_value      (item_value),
		.insert_position (insert_position),
		.done            (done),
		.status          (status),
		.removed_value   (removed_value),
		.found_position  (found_position),
		.list_length     (list_length)
	);

	ordered_list_engine_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.item_value      (item_value),
		.insert_position (insert_position),
		.done            (done),
		.status          (status),
		.removed_value   (removed_value),
		.found_position  (found_position),
		.list_length     (list_length),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#200_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic issue(input logic [2:0] op, input logic [31:0] value,
			input logic [7:0] pos, input int idle_pct);
		start <= 1'b1;
		req_type <= op;
		item_value <= value;
		insert_position <= pos;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// mode 0 fills the list, mode 1 drains it, mode 2 mixes
	function automatic logic [2:0] pick_op(input int mode);
		int r;
		r = $urandom_range(99);
		if (mode == 0) begin
			if (r < 25) return REQ_INS_FRONT;
			if (r < 50) return REQ_INS_BACK;
			if (r < 72) return REQ_INS_POS;
			if (r < 80) return REQ_DEL_FRONT;
			if (r < 86) return REQ_DEL_BACK;
			if (r < 95) return REQ_SEARCH;
		end else if (mode == 1) begin
			if (r < 8) return REQ_INS_FRONT;
			if (r < 16) return REQ_INS_BACK;
			if (r < 24) return REQ_INS_POS;
			if (r < 50) return REQ_DEL_FRONT;
			if (r < 74) return REQ_DEL_BACK;
			if (r < 90) return REQ_SEARCH;
		end else begin
			if (r < 15) return REQ_INS_FRONT;
			if (r < 30) return REQ_INS_BACK;
			if (r < 45) return REQ_INS_POS;
			if (r < 60) return REQ_DEL_FRONT;
			if (r < 75) return REQ_DEL_BACK;
			if (r < 93) return REQ_SEARCH;
		end
		if (r < 98) return REQ_LENGTH;
		return REQ_UNUSED;
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
		return $urandom();
	endfunction

	function automatic logic [7:0] pick_pos();
		if ($urandom_range(4) == 0) return 8'($urandom_range(255));
		return 8'($urandom_range(18));
	endfunction

	initial begin
		int idle_pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, position bounds, first match, unused code
		issue(REQ_SEARCH, 32'h0, 8'd0, 36);
		issue(REQ_DEL_FRONT, 32'h0, 8'd0, 36);
		issue(REQ_DEL_BACK, 32'h0, 8'd0, 36);
		issue(REQ_INS_POS, 32'h1, 8'd0, 36);
		issue(REQ_INS_POS, 32'h1, 8'd2, 36);
		issue(REQ_INS_POS, 32'h7FFF_FFFF, 8'd1, 36);
		issue(REQ_INS_FRONT, 32'h8000_0000, 8'd0, 36);
		issue(REQ_INS_BACK, 32'hFFFF_FFFF, 8'd255, 36);
		issue(REQ_INS_POS, 32'h0, 8'd4, 36);
		issue(REQ_INS_POS, 32'h1, 8'd6, 36);
		issue(REQ_INS_POS, 32'h1, 8'd255, 36);
		issue(REQ_INS_POS, 32'h5A5A_5A5A, 8'd2, 36);
		issue(REQ_INS_BACK, 32'h8000_0000, 8'd0, 36);
		issue(REQ_SEARCH, 32'h8000_0000, 8'd0, 36);
		issue(REQ_SEARCH, 32'h0, 8'd0, 36);
		issue(REQ_SEARCH, 32'h0001_2345, 8'd0, 36);
		issue(REQ_LENGTH, 32'hFFFF_FFFF, 8'd255, 36);
		issue(REQ_UNUSED, 32'h0, 8'd0, 36);
		issue(REQ_DEL_FRONT, 32'h0, 8'd0, 36);
		issue(REQ_DEL_BACK, 32'h0, 8'd0, 36);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
			for (int n = 0; n < PER_PHASE; n++) begin
				issue(pick_op((n / BLOCK_LEN) % 3), pick_value(), pick_pos(), idle_pct);
			end
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
